// ===== src/lfsc_pkg.sv =====
package lfsc_pkg;

    // Default nesting capacity
    localparam int LEVELS_DEF = 64;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int ERR_W  = 10;
    localparam int GRP_W  = 10;
    localparam int DEEP_W = 6;
    localparam int CNT_W  = 4;   // [1:0] connectives, [3:2] operands

    localparam logic [GRP_W-1:0]  GRP_INIT = GRP_W'(2);
    localparam logic [GRP_W-1:0]  GRP_MAX  = GRP_W'(1023);
    localparam logic [DEEP_W-1:0] DEEP_MAX = DEEP_W'(63);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFF = 8'h20;

    // Error mask bit positions
    localparam int E_BAD_CHAR = 0;
    localparam int E_TRAILING = 1;
    localparam int E_NO_OPEN  = 2;
    localparam int E_NO_CLOSE = 3;
    localparam int E_UNBAL    = 4;
    localparam int E_CONN_POS = 5;
    localparam int E_BANG     = 6;
    localparam int E_CONN_CNT = 7;
    localparam int E_OPND_CNT = 8;
    localparam int E_TOO_DEEP = 9;

    // One result transaction
    typedef struct packed {
        logic [ERR_W-1:0]  error_mask;
        logic [GRP_W-1:0]  group_count;
        logic [DEEP_W-1:0] deepest;
    } t_result;

    function automatic logic is_conn(input logic [CHAR_W-1:0] c);
        return (c == CH_GT) || (c == CH_AMP) || (c == CH_BAR);
    endfunction

endpackage

// ===== src/logic_formula_syntax_checker_unit.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// input    | in        | i_valid / o_ready   | i_char_code[7:0], i_last
// result   | out       | o_valid / i_ready   | o_error_mask[9:0], o_group_count[9:0],
//          |           |                     | o_deepest[5:0]
//
// One character per cycle while o_ready is high. A result is registered into a
// two-entry output buffer when its last character is taken.
// o_ready falls only while both buffer slots hold results.
// The per-level counter RAM has one read and one write port; the level below the
// current one is read every cycle so that a ')' needs no wait.
// Synchronous active-low reset; the RAM is not cleared, each entry is written
// before it is ever read.
module logic_formula_syntax_checker_unit #(
    parameter int LEVELS = lfsc_pkg::LEVELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lfsc_pkg::CHAR_W-1:0]         i_char_code,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lfsc_pkg::ERR_W-1:0]          o_error_mask,
    output logic [lfsc_pkg::GRP_W-1:0]          o_group_count,
    output logic [lfsc_pkg::DEEP_W-1:0]         o_deepest
);

    localparam int DEEP_TOP = (LEVELS - 1 > 63) ? 63 : LEVELS - 1;

    logic              in_accept;
    logic              res_valid;
    logic              buf_full;
    lfsc_pkg::t_result res;
    lfsc_pkg::t_result out_data;

    assign o_ready   = !buf_full;
    assign in_accept = i_valid && o_ready;

    lfsc_core #(
        .LEVELS (LEVELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lfsc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_error_mask  = out_data.error_mask;
    assign o_group_count = out_data.group_count;
    assign o_deepest     = out_data.deepest;

    // A result is only produced when the buffer has room for it
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> o_ready)
        else $error("result pushed into full output buffer");

    // Group count never drops below its start value
    a_group_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_group_count >= lfsc_pkg::GRP_INIT))
        else $error("group count below two");

    // Too-deep error implies the deepest level reached the top level
    a_too_deep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_mask[lfsc_pkg::E_TOO_DEEP]) |-> (int'(o_deepest) == DEEP_TOP))
        else $error("too-deep error without reaching top level");

endmodule

// ===== src/lfsc_ram.sv =====
module lfsc_ram #(
    parameter int WIDTH = lfsc_pkg::CNT_W,
    parameter int DEPTH = lfsc_pkg::LEVELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lfsc_core.sv =====
module lfsc_core #(
    parameter int LEVELS = lfsc_pkg::LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [lfsc_pkg::CHAR_W-1:0]   i_char_code,
    input  logic                          i_last,
    output logic                          o_res_valid,
    output lfsc_pkg::t_result             o_res
);

    localparam int AW = $clog2(LEVELS);
    localparam int NW = $clog2(LEVELS + 1);
    localparam int CW = (NW > lfsc_pkg::DEEP_W) ? NW : lfsc_pkg::DEEP_W;

    typedef enum logic {
        PH_FIRST,
        PH_RUN
    } t_phase;

    // Registers
    t_phase                          r_phase;
    logic [NW-1:0]                   r_nest;
    logic                            r_neg;      // nesting dropped below level 0
    logic [lfsc_pkg::CNT_W-1:0]      r_cur;      // cached counters of current level
    logic                            r_use_rd;   // current level comes from RAM read
    logic [lfsc_pkg::CHAR_W-1:0]     r_prev;
    logic                            r_bang_pend;
    logic [lfsc_pkg::ERR_W-1:0]      r_err;
    logic [lfsc_pkg::GRP_W-1:0]      r_grp;
    logic [lfsc_pkg::DEEP_W-1:0]     r_deep;

    // Next values
    t_phase                          n_phase;
    logic [NW-1:0]                   n_nest;
    logic                            n_neg;
    logic [lfsc_pkg::CNT_W-1:0]      n_cur;
    logic                            n_use_rd;
    logic [lfsc_pkg::CHAR_W-1:0]     n_prev;
    logic                            n_bang_pend;
    logic [lfsc_pkg::ERR_W-1:0]      n_err;
    logic [lfsc_pkg::GRP_W-1:0]      n_grp;
    logic [lfsc_pkg::DEEP_W-1:0]     n_deep;

    // Combinational
    logic [lfsc_pkg::CHAR_W-1:0]     fold;
    logic                            f_conn;
    logic                            f_opnd;
    logic                            f_alpha;
    logic [lfsc_pkg::ERR_W-1:0]      err_a;
    logic                            halted_a;
    logic                            do_check;
    logic                            checked_end;
    logic [lfsc_pkg::CNT_W-1:0]      cur;
    logic [lfsc_pkg::CNT_W-1:0]      rd_data;
    logic [1:0]                      cc;
    logic [1:0]                      oc;
    logic [NW-1:0]                   nest_m1;
    logic [CW-1:0]                   d_ext;
    logic                            ram_we;
    logic [lfsc_pkg::CHAR_W-1:0]     prev_end;
    lfsc_pkg::t_result               res;

    // Level counter store, one entry per nesting level
    lfsc_ram #(
        .WIDTH (lfsc_pkg::CNT_W),
        .DEPTH (LEVELS)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_nest[AW-1:0]),
        .i_wdata ({oc, cc}),
        .i_raddr (nest_m1[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Level below is always being read so a ')' can pick it up next cycle
    assign nest_m1 = r_nest - NW'(1);
    assign cur     = r_use_rd ? rd_data : r_cur;
    assign d_ext   = CW'(r_nest);

    // Classify the folded character
    always_comb begin
        fold = i_char_code;
        if (i_char_code >= lfsc_pkg::CH_LA && i_char_code <= lfsc_pkg::CH_LZ) begin
            fold = i_char_code - lfsc_pkg::CASE_OFF;
        end
        f_alpha = (fold >= lfsc_pkg::CH_UA) && (fold <= lfsc_pkg::CH_UZ);
        f_conn  = lfsc_pkg::is_conn(fold);
        f_opnd  = (fold == lfsc_pkg::CH_LPAR) || f_alpha;
    end

    // Deferred '!' rule of the previous character, then halt test
    always_comb begin
        err_a = r_err;
        if (r_phase == PH_RUN && r_bang_pend && !lfsc_pkg::is_conn(i_char_code)) begin
            err_a[lfsc_pkg::E_BANG] = 1'b1;
        end
        halted_a = |(err_a & ~(lfsc_pkg::ERR_W'(1) << lfsc_pkg::E_NO_OPEN));
        do_check = i_accept && (r_phase == PH_RUN) && !halted_a;
    end

    // Per-character check, level update and end checks
    always_comb begin
        n_phase     = r_phase;
        n_nest      = r_nest;
        n_neg       = r_neg;
        n_cur       = cur;
        n_use_rd    = 1'b0;
        n_prev      = r_prev;
        n_bang_pend = r_bang_pend;
        n_err       = r_err;
        n_grp       = r_grp;
        n_deep      = r_deep;
        ram_we      = 1'b0;
        cc          = cur[1:0];
        oc          = cur[3:2];
        checked_end = 1'b0;
        prev_end    = r_prev;

        if (i_accept) begin
            n_err       = err_a;
            n_bang_pend = 1'b0;
        end

        if (i_accept && r_phase == PH_FIRST) begin
            if (i_char_code != lfsc_pkg::CH_LPAR) begin
                n_err[lfsc_pkg::E_NO_OPEN] = 1'b1;
            end
            n_prev      = i_char_code;
            n_phase     = PH_RUN;
            checked_end = 1'b1;
        end

        if (do_check) begin
            checked_end = 1'b1;
            if (!(fold == lfsc_pkg::CH_SPACE || fold == lfsc_pkg::CH_BANG || f_conn ||
                  fold == lfsc_pkg::CH_LPAR || fold == lfsc_pkg::CH_RPAR || f_alpha)) begin
                n_err[lfsc_pkg::E_BAD_CHAR] = 1'b1;
            end
            if (f_conn && cc != 2'd3) begin
                cc = cc + 2'd1;
            end
            if (f_opnd && oc != 2'd3) begin
                oc = oc + 2'd1;
            end
            if (f_conn && oc != 2'd1) begin
                n_err[lfsc_pkg::E_CONN_POS] = 1'b1;
            end
            // '!' needs a connective on one side
            if (fold == lfsc_pkg::CH_BANG && !lfsc_pkg::is_conn(r_prev)) begin
                if (i_last) begin
                    n_err[lfsc_pkg::E_BANG] = 1'b1;
                end else begin
                    n_bang_pend = 1'b1;
                end
            end
            n_cur = {oc, cc};
            if (d_ext > CW'(r_deep)) begin
                n_deep = (d_ext > CW'(lfsc_pkg::DEEP_MAX)) ? lfsc_pkg::DEEP_MAX
                                                           : d_ext[lfsc_pkg::DEEP_W-1:0];
            end
            if (fold == lfsc_pkg::CH_LPAR) begin
                // Save this level, open a fresh one
                ram_we = 1'b1;
                if (r_grp != lfsc_pkg::GRP_MAX) begin
                    n_grp = r_grp + lfsc_pkg::GRP_W'(1);
                end
                if (r_nest == NW'(LEVELS - 1)) begin
                    n_err[lfsc_pkg::E_TOO_DEEP] = 1'b1;
                end
                n_nest = r_nest + NW'(1);
                n_cur  = '0;
            end else if (fold == lfsc_pkg::CH_RPAR) begin
                if (cc != 2'd1) begin
                    n_err[lfsc_pkg::E_CONN_CNT] = 1'b1;
                end
                if (oc != 2'd2) begin
                    n_err[lfsc_pkg::E_OPND_CNT] = 1'b1;
                end
                n_use_rd = 1'b1;
                if (r_nest == '0) begin
                    n_neg = 1'b1;
                    if (!i_last) begin
                        n_err[lfsc_pkg::E_TRAILING] = 1'b1;
                    end
                end else begin
                    n_nest = nest_m1;
                end
            end
            n_prev = fold;
        end

        prev_end = n_prev;
        if (i_accept && i_last && checked_end) begin
            if (prev_end != lfsc_pkg::CH_RPAR) begin
                n_err[lfsc_pkg::E_NO_CLOSE] = 1'b1;
            end
            if (!n_neg) begin
                n_err[lfsc_pkg::E_UNBAL] = 1'b1;
            end
        end

        res.error_mask  = n_err;
        res.group_count = n_grp;
        res.deepest     = n_deep;
    end

    // State and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase     <= PH_FIRST;
            r_nest      <= '0;
            r_neg       <= 1'b0;
            r_cur       <= '0;
            r_use_rd    <= 1'b0;
            r_prev      <= '0;
            r_bang_pend <= 1'b0;
            r_err       <= '0;
            r_grp       <= lfsc_pkg::GRP_INIT;
            r_deep      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_nest      <= n_nest;
            r_neg       <= n_neg;
            r_cur       <= n_cur;
            r_use_rd    <= n_use_rd;
            r_prev      <= n_prev;
            r_bang_pend <= n_bang_pend;
            r_err       <= n_err;
            r_grp       <= n_grp;
            r_deep      <= n_deep;
        end
    end

    assign o_res_valid = i_accept && i_last;
    assign o_res       = res;

endmodule

// ===== src/lfsc_outbuf.sv =====
module lfsc_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lfsc_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output lfsc_pkg::t_result o_data
);

    logic              r_a_valid;
    logic              r_b_valid;
    lfsc_pkg::t_result r_a;
    lfsc_pkg::t_result r_b;
    logic              a_free;

    // Head slot frees when empty or taken this cycle
    assign a_free = !r_a_valid || i_ready;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (a_free) begin
            if (r_b_valid) begin
                r_a_valid <= 1'b1;
                r_b_valid <= i_push;
            end else begin
                r_a_valid <= i_push;
            end
        end else if (i_push) begin
            r_b_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (a_free) begin
            if (r_b_valid) begin
                r_a <= r_b;
                r_b <= i_data;
            end else begin
                r_a <= i_data;
            end
        end else if (i_push) begin
            r_b <= i_data;
        end
    end

    assign o_full  = r_b_valid;
    assign o_valid = r_a_valid;
    assign o_data  = r_a;

endmodule

// ===== tb/lfsc_verdict_checker.sv =====
module lfsc_verdict_checker
    import lfsc_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [ERR_W-1:0]  i_error_mask,
    input  logic [GRP_W-1:0]  i_group_count,
    input  logic [DEEP_W-1:0] i_deepest,
    output int                o_fault_count,
    output int                o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Where the formula scan stands: first character, one seen, one held back
    typedef enum logic [1:0] {AWAIT_OPEN, HOLD_ONE, HOLD_NEXT} t_cursor;

    // Predicted scanner state
    logic [CNT_W-1:0]  lvl_cnt [LEVELS];   // [1:0] connectives, [3:2] operands
    int                depth_now;
    logic [CHAR_W-1:0] held_char;
    logic [CHAR_W-1:0] prior_char;
    t_cursor           cursor;
    logic [ERR_W-1:0]  err_acc;
    logic [GRP_W-1:0]  grp_acc;
    logic [DEEP_W-1:0] deep_acc;

    t_result verdicts_due [$];
    int      faults = 0;

    initial begin
        o_fault_count = 0;
        o_due_count   = 0;
    end

    function automatic bit is_connective(input logic [CHAR_W-1:0] c);
        return (c == CH_GT) || (c == CH_AMP) || (c == CH_BAR);
    endfunction

    // Any error except the missing opening paren stops further checking
    function automatic bit scan_stopped();
        logic [ERR_W-1:0] rest;
        rest = err_acc;
        rest[E_NO_OPEN] = 1'b0;
        return rest != '0;
    endfunction

    function automatic void clear_formula();
        foreach (lvl_cnt[k]) lvl_cnt[k] = '0;
        depth_now  = 0;
        held_char  = '0;
        prior_char = '0;
        cursor     = AWAIT_OPEN;
        err_acc    = '0;
        grp_acc    = GRP_INIT;
        deep_acc   = '0;
    endfunction

    // Check one character after the first, with its neighbors
    function automatic void scan_char(input logic [CHAR_W-1:0] c_in,
                                      input logic [CHAR_W-1:0] p,
                                      input logic [CHAR_W-1:0] n,
                                      input bit at_end);
        logic [CHAR_W-1:0] c;
        bit                conn;
        bit                opnd;
        bit                letter;
        logic [1:0]        cc;
        logic [1:0]        oc;
        int                d;
        c = c_in;
        d = depth_now;
        if (c >= CH_LA && c <= CH_LZ) c = c - CASE_OFF;
        conn   = is_connective(c);
        letter = (c >= CH_UA && c <= CH_UZ);
        opnd   = (c == CH_LPAR) || letter;
        if (!(c == CH_SPACE || c == CH_BANG || conn || c == CH_LPAR || c == CH_RPAR || letter))
            err_acc[E_BAD_CHAR] = 1'b1;
        if (d < 0 || d >= LEVELS) return;

        // Per-level group rules
        cc = lvl_cnt[d][1:0];
        oc = lvl_cnt[d][3:2];
        if (conn && cc != 2'd3) cc = cc + 2'd1;
        if (opnd && oc != 2'd3) oc = oc + 2'd1;
        if (conn && oc != 2'd1) err_acc[E_CONN_POS] = 1'b1;
        if (c == CH_BANG && !is_connective(n) && !is_connective(p))
            err_acc[E_BANG] = 1'b1;
        if (c == CH_RPAR) begin
            if (cc != 2'd1) err_acc[E_CONN_CNT] = 1'b1;
            if (oc != 2'd2) err_acc[E_OPND_CNT] = 1'b1;
            cc = '0;
            oc = '0;
        end
        lvl_cnt[d] = {oc, cc};

        if (c == CH_LPAR && grp_acc < GRP_MAX) grp_acc = grp_acc + 1'b1;
        if (d > int'(deep_acc)) deep_acc = (d > 63) ? DEEP_MAX : DEEP_W'(d);

        // Nesting update; a new level starts with cleared counters
        if (c == CH_LPAR) begin
            depth_now = d + 1;
            if (depth_now >= LEVELS) err_acc[E_TOO_DEEP] = 1'b1;
            else lvl_cnt[depth_now] = '0;
        end else if (c == CH_RPAR) begin
            depth_now = d - 1;
        end
        if (depth_now == -1 && !at_end) err_acc[E_TRAILING] = 1'b1;
        prior_char = c;
    endfunction

    // Advance by one accepted character; returns 1 when a verdict is due
    function automatic bit take_char(input logic [CHAR_W-1:0] c, input bit fin,
                                     output t_result r);
        bit checked_end;
        r = '0;
        if (cursor == AWAIT_OPEN) begin
            if (c != CH_LPAR) err_acc[E_NO_OPEN] = 1'b1;
            prior_char  = c;
            cursor      = HOLD_ONE;
            checked_end = 1'b1;
        end else begin
            if (cursor == HOLD_NEXT && !scan_stopped())
                scan_char(held_char, prior_char, c, 1'b0);
            if (!fin) begin
                held_char = c;
                cursor    = HOLD_NEXT;
                return 1'b0;
            end
            checked_end = !scan_stopped();
            if (checked_end) scan_char(c, prior_char, '0, 1'b1);
        end
        if (!fin) return 1'b0;

        if (checked_end) begin
            if (prior_char != CH_RPAR) err_acc[E_NO_CLOSE] = 1'b1;
            if (depth_now != -1) err_acc[E_UNBAL] = 1'b1;
        end
        r.error_mask  = err_acc;
        r.group_count = grp_acc;
        r.deepest     = deep_acc;
        clear_formula();
        return 1'b1;
    endfunction

    // Predict on input transactions, compare on result transactions
    always @(posedge i_clk) begin : watch
        t_result fresh;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            clear_formula();
            verdicts_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (take_char(i_char_code, i_last, fresh)) verdicts_due.push_back(fresh);
            end
            if (i_out_valid && i_out_ready) begin
                got.error_mask  = i_error_mask;
                got.group_count = i_group_count;
                got.deepest     = i_deepest;
                if (verdicts_due.size() == 0) begin
                    if (faults < 10)
                        $display("unexpected result: error_mask %h group_count %0d deepest %0d",
                                 got.error_mask, got.group_count, got.deepest);
                    faults++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.error_mask !== want.error_mask ||
                        got.group_count !== want.group_count ||
                        got.deepest !== want.deepest) begin
                        if (faults < 10)
                            $display({"mismatch: error_mask exp %h got %h, ",
                                      "group_count exp %0d got %0d, deepest exp %0d got %0d"},
                                     want.error_mask, got.error_mask,
                                     want.group_count, got.group_count,
                                     want.deepest, got.deepest);
                        faults++;
                    end
                end
            end
        end
        o_fault_count <= faults;
        o_due_count   <= verdicts_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lfsc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [CHAR_W-1:0] i_char_code   = '0;
    logic              i_last        = 1'b0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [ERR_W-1:0]  o_error_mask;
    logic [GRP_W-1:0]  o_group_count;
    logic [DEEP_W-1:0] o_deepest;

    int fault_count;
    int due_count;

    logic [CHAR_W-1:0] formula_text [$];
    bit                tx_calm      = 1'b0;
    bit                random_phase = 1'b0;

    logic_formula_syntax_checker_unit #(.LEVELS(LEVELS_DEF)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_code  (i_char_code),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_error_mask (o_error_mask),
        .o_group_count(o_group_count),
        .o_deepest    (o_deepest)
    );

    lfsc_verdict_checker #(.LEVELS(LEVELS_DEF)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_char_code  (i_char_code),
        .i_last       (i_last),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_error_mask (o_error_mask),
        .i_group_count(o_group_count),
        .i_deepest    (o_deepest),
        .o_fault_count(fault_count),
        .o_due_count  (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off, then a calm stretch
    initial begin : result_sink
        int  tick;
        int  hold_left;
        int  calm_left;
        bit  held;
        tick      = 0;
        hold_left = 0;
        calm_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (random_phase && !held) begin
                tick++;
                if (tick == 80) begin
                    held      = 1'b1;
                    hold_left = 300;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
                if (hold_left == 0) calm_left = 600;
            end else if (calm_left > 0) begin
                calm_left--;
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    // Offer one character; called and returns at a falling edge
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
        int gap;
        gap = 0;
        if (!tx_calm) begin
            while ($urandom_range(99) < 22) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last      <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_formula();
        foreach (formula_text[k]) send_char(formula_text[k], k == formula_text.size() - 1);
        formula_text.delete();
    endtask

    task automatic send_string(input string s);
        for (int k = 0; k < s.len(); k++) formula_text.push_back(s[k]);
        send_formula();
    endtask

    function automatic logic [CHAR_W-1:0] any_letter();
        return ($urandom_range(1) ? CH_LA : CH_UA) + CHAR_W'($urandom_range(25));
    endfunction

    function automatic logic [CHAR_W-1:0] any_connective();
        case ($urandom_range(2))
            0:       return CH_GT;
            1:       return CH_AMP;
            default: return CH_BAR;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] any_symbol();
        case ($urandom_range(7))
            0:       return CH_SPACE;
            1:       return CH_BANG;
            2:       return CH_AMP;
            3:       return CH_GT;
            4:       return CH_BAR;
            5:       return CH_LPAR;
            6:       return CH_RPAR;
            default: return any_letter();
        endcase
    endfunction

    function automatic void maybe_space();
        if ($urandom_range(9) == 0) formula_text.push_back(CH_SPACE);
    endfunction

    // Well-formed group with random content
    function automatic void put_group(input int budget);
        formula_text.push_back(CH_LPAR);
        maybe_space();
        put_operand(budget);
        maybe_space();
        formula_text.push_back(any_connective());
        if ($urandom_range(3) == 0) formula_text.push_back(CH_BANG);
        maybe_space();
        put_operand(budget);
        maybe_space();
        formula_text.push_back(CH_RPAR);
    endfunction

    function automatic void put_operand(input int budget);
        if (budget > 0 && $urandom_range(99) < 40) put_group(budget - 1);
        else formula_text.push_back(any_letter());
    endfunction

    // Left-leaning chain of k nested groups
    function automatic void put_chain(input int k);
        repeat (k) formula_text.push_back(CH_LPAR);
        formula_text.push_back(CH_UA);
        formula_text.push_back(CH_AMP);
        formula_text.push_back(CH_UA + 8'd1);
        formula_text.push_back(CH_RPAR);
        repeat (k - 1) begin
            formula_text.push_back(CH_AMP);
            formula_text.push_back(CH_UA + 8'd2);
            formula_text.push_back(CH_RPAR);
        end
    endfunction

    // One random edit: replace, insert or delete
    function automatic void mangle();
        int pos;
        pos = $urandom_range(formula_text.size() - 1);
        case ($urandom_range(2))
            0: formula_text[pos] = CHAR_W'($urandom_range(255));
            1: formula_text.insert(pos, any_symbol());
            default: if (formula_text.size() > 1) formula_text.delete(pos);
        endcase
    endfunction

    function automatic void put_noise();
        int len;
        len = $urandom_range(1, 6);
        formula_text.push_back($urandom_range(1) ? CH_LPAR : CHAR_W'($urandom_range(255)));
        repeat (len - 1) formula_text.push_back(CHAR_W'($urandom_range(255)));
    endfunction

    // Stimulus and verdict
    initial begin : stimulus
        int random_chars;
        int n_form;
        int pick;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed formulas
        send_string("(A&B)");
        send_string("(a|z)");
        send_string("( A > B )");
        send_string("(A>!B)");
        send_string("(A!&B)");
        send_string("(!A&B)");
        send_string("(A&B!)");
        send_string("((A&B)&(C|d))");
        send_string("A");
        send_string(")");
        send_string("(");
        send_string("X(A&B)");
        send_string("(A&B)C");
        send_string("(A&B");
        send_string("(A&&B)");
        send_string("(AB&C)");
        send_string("(A&B|C)");
        send_string("(A)");
        send_string("(A#B)");
        formula_text = '{CH_LPAR, 8'h00, CH_AMP, CH_UA, CH_RPAR};
        send_formula();
        formula_text = '{8'hFF, CH_UA, CH_BAR, CH_UZ, 8'hFF};
        send_formula();
        put_chain(64);
        send_formula();
        put_chain(65);
        send_formula();

        // Random formulas, mostly well-formed
        random_phase = 1'b1;
        random_chars = 0;
        n_form       = 0;
        while (random_chars < 1250) begin
            tx_calm = (n_form >= 40 && n_form < 75);
            pick = $urandom_range(99);
            if (pick < 62) begin
                put_group($urandom_range(3));
            end else if (pick < 77) begin
                put_group($urandom_range(2));
                mangle();
            end else if (pick < 90) begin
                put_noise();
            end else if (pick < 98) begin
                put_group($urandom_range(1));
                case ($urandom_range(2))
                    0:       formula_text.push_back(any_symbol());
                    1:       void'(formula_text.pop_back());
                    default: formula_text.push_front(CH_LPAR);
                endcase
            end else begin
                put_chain($urandom_range(1, 66));
            end
            random_chars += formula_text.size();
            send_formula();
            n_form++;
        end
        tx_calm = 1'b0;
        i_valid <= 1'b0;

        // Drain and settle
        while (due_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
